// File: hdl/asc_pkg.sv
// Package for the adjacent strip clusterer: hit and cluster payload types,
// the internal result bundle and the detector strip count. No dependencies.
`default_nettype none

package asc_pkg;

  localparam int unsigned STRIP_COUNT = 256;

  localparam logic [8:0]  WIDTH_MAX = 9'h1FF;
  localparam logic [23:0] SUM_MAX   = 24'hFFFFFF;

  typedef struct packed {
    logic [7:0]  strip_number;
    logic [15:0] charge;
    logic [5:0]  layer_id;
    logic [6:0]  plane_id;
    logic        end_of_layer;
  } hit_t;

  typedef struct packed {
    logic [7:0]  first_strip;
    logic [7:0]  final_strip;
    logic [7:0]  peak_strip;
    logic [8:0]  cluster_width;
    logic [23:0] charge_sum;
    logic [5:0]  cluster_layer;
    logic [6:0]  cluster_plane;
    logic        last_of_run;
  } clu_t;

  // Clusters produced by one accepted hit, in output order.
  typedef struct packed {
    logic [1:0] count;
    clu_t       slot0;
    clu_t       slot1;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/adjacent_strip_clusterer_core.sv
// Top level of the adjacent strip clusterer: running cluster plus result queue.
// Depends on asc_pkg, asc_run and asc_queue.
`default_nettype none

// Groups one layer's strip hits, sent in ascending strip order, into clusters
// of consecutive strips and reports first, final and peak strip, width,
// saturating charge sum and tags. A cluster enters a four-entry result
// queue as the hit that closes it is taken; a hit that both breaks the open
// cluster and carries end of layer yields two clusters. Clusters leave one
// per cycle while the output is ready. One hit request is taken per cycle;
// the hit input is held off while the queue has fewer than two free entries.
module adjacent_strip_clusterer_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          hit_valid_i,
  output logic          hit_ready_o,
  input  asc_pkg::hit_t hit_i,
  output logic          clu_valid_o,
  input  logic          clu_ready_i,
  output asc_pkg::clu_t clu_o
);
  import asc_pkg::*;

  res_t res;
  logic accept;

  assign accept = hit_valid_i && hit_ready_o;

  asc_run u_run (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .hit_i    (hit_i),
    .res_o    (res)
  );

  asc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (res),
    .space_o (hit_ready_o),
    .valid_o (clu_valid_o),
    .ready_i (clu_ready_i),
    .clu_o   (clu_o)
  );

endmodule

`default_nettype wire

// File: hdl/asc_run.sv
// Running cluster state of the adjacent strip clusterer and the clusters
// that each accepted hit closes. Depends on asc_pkg.
`default_nettype none

module asc_run (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  asc_pkg::hit_t hit_i,
  output asc_pkg::res_t res_o
);
  import asc_pkg::*;

  logic        open_q, open_d;
  logic [7:0]  first_q, first_d;
  logic [7:0]  prev_q, prev_d;
  logic [8:0]  width_q, width_d;
  logic [23:0] sum_q, sum_d;
  logic [15:0] peak_q_q, peak_q_d;
  logic [7:0]  peak_s_q, peak_s_d;
  logic [5:0]  layer_q, layer_d;
  logic [6:0]  plane_q, plane_d;

  logic        adj;
  logic        brk_emit;
  logic [8:0]  next_strip;
  logic [24:0] sum_ext;
  clu_t        old_clu, new_clu;

  always_comb begin
    next_strip = {1'b0, prev_q} + 9'd1;
    adj = open_q && ({1'b0, hit_i.strip_number} == next_strip)
          && (32'(next_strip) < STRIP_COUNT);
    brk_emit = open_q && !adj;
    sum_ext  = {1'b0, sum_q} + {9'd0, hit_i.charge};

    if (adj) begin
      first_d  = first_q;
      width_d  = (width_q != WIDTH_MAX) ? width_q + 9'd1 : width_q;
      sum_d    = sum_ext[24] ? SUM_MAX : sum_ext[23:0];
      if (hit_i.charge > peak_q_q) begin
        peak_q_d = hit_i.charge;
        peak_s_d = hit_i.strip_number;
      end else begin
        peak_q_d = peak_q_q;
        peak_s_d = peak_s_q;
      end
    end else begin
      first_d  = hit_i.strip_number;
      width_d  = 9'd1;
      sum_d    = {8'd0, hit_i.charge};
      peak_q_d = hit_i.charge;
      peak_s_d = hit_i.strip_number;
    end
    prev_d  = hit_i.strip_number;
    layer_d = hit_i.layer_id;
    plane_d = hit_i.plane_id;
    open_d  = !hit_i.end_of_layer;

    old_clu = '{first_strip: first_q, final_strip: prev_q, peak_strip: peak_s_q,
                cluster_width: width_q, charge_sum: sum_q, cluster_layer: layer_q,
                cluster_plane: plane_q, last_of_run: !hit_i.end_of_layer};
    new_clu = '{first_strip: first_d, final_strip: prev_d, peak_strip: peak_s_d,
                cluster_width: width_d, charge_sum: sum_d, cluster_layer: layer_d,
                cluster_plane: plane_d, last_of_run: 1'b1};

    res_o.count = accept_i ? (2'(brk_emit) + 2'(hit_i.end_of_layer)) : 2'd0;
    res_o.slot0 = brk_emit ? old_clu : new_clu;
    res_o.slot1 = new_clu;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      first_q  <= '0;
      prev_q   <= '0;
      width_q  <= '0;
      sum_q    <= '0;
      peak_q_q <= '0;
      peak_s_q <= '0;
      layer_q  <= '0;
      plane_q  <= '0;
    end else if (accept_i) begin
      open_q   <= open_d;
      first_q  <= first_d;
      prev_q   <= prev_d;
      width_q  <= width_d;
      sum_q    <= sum_d;
      peak_q_q <= peak_q_d;
      peak_s_q <= peak_s_d;
      layer_q  <= layer_d;
      plane_q  <= plane_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/asc_queue.sv
// Four-entry result queue of the adjacent strip clusterer: takes up to two
// clusters per cycle, hands out one per cycle while ready. Depends on asc_pkg.
`default_nettype none

module asc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  asc_pkg::res_t res_i,
  output logic          space_o,
  output logic          valid_o,
  input  logic          ready_i,
  output asc_pkg::clu_t clu_o
);
  import asc_pkg::*;

  clu_t       mem_q [4];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;
  logic       pop;

  assign valid_o = (count_q != 3'd0);
  assign clu_o   = mem_q[rd_ptr_q];
  // Room for the worst case of two clusters from the next request.
  assign space_o = (count_q <= 3'd2);
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q + res_i.count;
    rd_ptr_d = rd_ptr_q + 2'(pop);
    count_d  = count_q + {1'b0, res_i.count} - 3'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (res_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= res_i.slot0;
    end
    if (res_i.count == 2'd2) begin
      mem_q[wr_ptr_q + 2'd1] <= res_i.slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/asc_checker.sv
// Port-level checks for adjacent_strip_clusterer_core and the bind that
// attaches them. Depends on asc_pkg.
`default_nettype none

module asc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          hit_valid_i,
  input logic          hit_ready_o,
  input asc_pkg::hit_t hit_i,
  input logic          clu_valid_o,
  input logic          clu_ready_i,
  input asc_pkg::clu_t clu_o
);
  import asc_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clu_valid_o && !clu_ready_i |=> clu_valid_o && $stable(clu_o))
    else $error("cluster request dropped or changed while stalled");

  // End of layer always closes a cluster, so a result must be waiting.
  a_eol_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_valid_i && hit_ready_o && hit_i.end_of_layer |=> clu_valid_o)
    else $error("end of layer accepted without a cluster");

  a_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clu_valid_o |-> clu_o.cluster_width != 9'd0 && clu_o.final_strip >= clu_o.first_strip)
    else $error("malformed cluster");

  // Back pressure on hits only comes from results waiting on the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hit_ready_o |-> clu_valid_o)
    else $error("hit input stalled with no pending cluster");

endmodule

bind adjacent_strip_clusterer_core asc_checker u_asc_checker (.*);

`default_nettype wire
